// ----- rtl/core/http_chunked_body_decoder_unit_macros.svh -----
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// Assertion helpers; clocked on clk, off while arst_n is low.
`define HCBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define HCBD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/hcbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int COUNT_W       = 20;
	localparam int DATA_W        = 8;

	localparam logic [COUNT_W-1:0] BODY_LIMIT_RST = COUNT_W'(65535);

	// register word indexes
	localparam logic REG_BODY_LIMIT = 1'b0;

	// result kinds
	localparam logic [1:0] KIND_KEPT    = 2'd0;
	localparam logic [1:0] KIND_DROPPED = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic              fire;
		logic              restart;
		logic [DATA_W-1:0] data_byte;
	} step_t;

	typedef struct packed {
		logic               valid;
		logic [DATA_W-1:0]  out_byte;
		logic [1:0]         kind;
		logic [COUNT_W-1:0] body_count;
		logic               truncated;
		logic               success;
	} res_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hcbd_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface hcbd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  kind;
	logic [19:0] body_count;
	logic        truncated;
	logic        success;

	modport source (output valid, output out_byte, output kind, output body_count,
		output truncated, output success, input ready);
	modport sink (input valid, input out_byte, input kind, input body_count,
		input truncated, input success, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/http_chunked_body_decoder_unit.sv -----
// channel  | dir | transfer when        | payload
// body     | in  | valid & ready        | data_byte, restart
// result   | out | valid & ready        | out_byte, kind, body_count, truncated, success
// apb      | in  | psel&penable&pwrite  | body_limit at byte address 0
//
// One byte per cycle sustained while result.ready holds. A transfer lands in the input
// register; the parser steps it into the result register once that register is free
// or being drained. The parser's state registers carry its state from byte to byte.
// arst_n clears parser state, both valid flags and body_limit (back to 65535).
// While a result waits unaccepted the parser holds every byte, so body.ready drops
// as soon as the input register is occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "http_chunked_body_decoder_unit_macros.svh"

module http_chunked_body_decoder_unit
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hcbd_in_if.sink          body,
	hcbd_out_if.source       result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [COUNT_W-1:0] body_limit_q;

	logic              valid_s1;
	logic              restart_s1;
	logic [DATA_W-1:0] data_s1;
	logic              s1_fire;

	logic   out_valid_q;
	res_t   out_q;
	res_t   step_res;
	step_t  step;
	logic   out_load;
	logic   kept_res;
	logic   drop_res;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BODY_LIMIT) ? {{(32-COUNT_W){1'b0}}, body_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit_q <= BODY_LIMIT_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_BODY_LIMIT) begin
			body_limit_q <= pwdata[COUNT_W-1:0];
		end
	end

	// the parser steps only when the result register is free or being drained
	assign s1_fire    = valid_s1 && (!out_valid_q || result.ready);
	assign body.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			restart_s1 <= body.restart;
			data_s1    <= body.data_byte;
		end
	end

	assign step.fire      = s1_fire;
	assign step.restart   = restart_s1;
	assign step.data_byte = data_s1;

	hcbd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.body_limit(body_limit_q),
		.res       (step_res)
	);

	assign out_load = step_res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= step_res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_q.out_byte;
	assign result.kind       = out_q.kind;
	assign result.body_count = out_q.body_count;
	assign result.truncated  = out_q.truncated;
	assign result.success    = out_q.success;

	assign kept_res = step_res.valid && step_res.kind == KIND_KEPT;
	assign drop_res = step_res.valid && step_res.kind == KIND_DROPPED;

	`HCBD_NEVER(a_restart_silent, step.fire && step.restart && step_res.valid, "restart result")
	`HCBD_ASSERT(a_kept_in_limit, kept_res |-> (step_res.body_count <= body_limit_q), "over limit")
	`HCBD_ASSERT(a_drop_flags, drop_res |-> step_res.truncated, "drop without truncated flag")
	`HCBD_NEVER(a_no_overwrite, out_load && out_valid_q && !result.ready, "result overwritten")

endmodule

`default_nettype wire

// ----- rtl/core/hcbd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hcbd_parser
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire step_t              step,
	input  wire logic [COUNT_W-1:0] body_limit,
	output res_t                    res
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_SKIP,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] size_q, size_n;
	logic [SIZE_BITS-1:0] rem_q, rem_n;
	logic                 digits_done_q, digits_done_n;
	logic                 any_chunk_q, any_chunk_n;
	logic [COUNT_W-1:0]   kept_q, kept_n;
	logic                 dropped_q, dropped_n;
	logic                 trailer_ne_q, trailer_ne_n;

	logic [7:0] c;
	logic [4:0] hex;
	logic       size_zero;
	logic       size_sat;

	assign c         = step.data_byte;
	assign hex       = hex_value(c);
	assign size_zero = (size_q == '0);
	// one more digit would overflow when the top nibble is nonzero
	assign size_sat  = |size_q[SIZE_BITS-1 -: 4];

	always_comb begin
		phase_n       = phase_q;
		size_n        = size_q;
		rem_n         = rem_q;
		digits_done_n = digits_done_q;
		any_chunk_n   = any_chunk_q;
		kept_n        = kept_q;
		dropped_n     = dropped_q;
		trailer_ne_n  = trailer_ne_q;
		res           = '0;

		if (step.fire) begin
			if (step.restart) begin
				phase_n       = PH_SIZE;
				size_n        = '0;
				rem_n         = '0;
				digits_done_n = 1'b0;
				any_chunk_n   = 1'b0;
				kept_n        = '0;
				dropped_n     = 1'b0;
				trailer_ne_n  = 1'b0;
			end else begin
				case (phase_q)
					PH_SIZE: begin
						if (c == CH_LF) begin
							if (size_zero) begin
								phase_n      = PH_TRAILER;
								trailer_ne_n = 1'b0;
							end else begin
								rem_n       = size_q;
								any_chunk_n = 1'b1;
								phase_n     = PH_DATA;
							end
							size_n        = '0;
							digits_done_n = 1'b0;
						end else if (c != CH_CR && !digits_done_q) begin
							if (hex[4]) begin
								size_n = size_sat ? '1 : {size_q[SIZE_BITS-5:0], hex[3:0]};
							end else if (size_zero &&
									(c inside {CH_SP, CH_TAB, CH_VT, CH_FF})) begin
								// leading blank, skipped
							end else if (size_zero && c == CH_MINUS) begin
								phase_n        = PH_DONE;
								res.valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.body_count = kept_q;
								res.truncated  = dropped_q;
								res.success    = any_chunk_q | (kept_q == '0);
							end else begin
								digits_done_n = 1'b1;
							end
						end
					end
					PH_DATA: begin
						rem_n = rem_q - 1'b1;
						if (rem_q == SIZE_BITS'(1)) begin
							phase_n = PH_SKIP;
						end
						res.valid    = 1'b1;
						res.out_byte = c;
						if (kept_q < body_limit) begin
							kept_n        = kept_q + 1'b1;
							res.kind      = KIND_KEPT;
							res.truncated = dropped_q;
						end else begin
							dropped_n     = 1'b1;
							res.kind      = KIND_DROPPED;
							res.truncated = 1'b1;
						end
						res.body_count = kept_n;
					end
					PH_SKIP: begin
						if (c == CH_LF) begin
							phase_n       = PH_SIZE;
							size_n        = '0;
							digits_done_n = 1'b0;
						end
					end
					PH_TRAILER: begin
						if (c == CH_LF) begin
							if (!trailer_ne_q) begin
								phase_n        = PH_DONE;
								res.valid      = 1'b1;
								res.kind       = KIND_DONE;
								res.body_count = kept_q;
								res.truncated  = dropped_q;
								res.success    = any_chunk_q | (kept_q == '0);
							end else begin
								trailer_ne_n = 1'b0;
							end
						end else if (c != CH_CR) begin
							trailer_ne_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			size_q        <= '0;
			rem_q         <= '0;
			digits_done_q <= 1'b0;
			any_chunk_q   <= 1'b0;
			kept_q        <= '0;
			dropped_q     <= 1'b0;
			trailer_ne_q  <= 1'b0;
		end else begin
			phase_q       <= phase_n;
			size_q        <= size_n;
			rem_q         <= rem_n;
			digits_done_q <= digits_done_n;
			any_chunk_q   <= any_chunk_n;
			kept_q        <= kept_n;
			dropped_q     <= dropped_n;
			trailer_ne_q  <= trailer_ne_n;
		end
	end

endmodule

`default_nettype wire
